// ===== rtl/tafs_pkg.sv =====
// Shared types, constants and the arctangent table of the triangle angle block.
`timescale 1ns / 1ps
package tafs_pkg;

  typedef struct packed {
    logic [15:0] side_a;
    logic [15:0] side_b;
    logic [15:0] side_c;
  } in_item_t;

  typedef struct packed {
    logic [1:0] angle_index;
    logic [7:0] degrees;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       is_triangle;
    logic       last;
  } out_item_t;

  // classified item as it waits in the queue
  typedef struct packed {
    in_item_t sides;
    logic     is_tri;
  } job_t;

  // per-angle control that rides along the arithmetic pipeline
  typedef struct packed {
    logic [1:0] idx;
    logic       is_tri;
    logic       last;
  } tag_t;

  localparam logic [1:0] IDX_OPP_C = 2'd0;
  localparam logic [1:0] IDX_OPP_A = 2'd1;
  localparam logic [1:0] IDX_OPP_B = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;

  localparam int QUO_BITS    = 30;
  localparam int SEC_BITS    = 20;
  localparam int SCALED_BITS = 43;

  localparam logic [31:0] PI_Q30     = 32'd3373259426;
  // 648000 / 3.14159265 scaled: 1440000000000 = HI * 2^32 + LO
  localparam logic [30:0] SEC_MUL_LO = 31'd1185955840;
  localparam logic [8:0]  SEC_MUL_HI = 9'd335;
  localparam logic [22:0] SEC_DIV    = 23'd6981317;
  // floor(1440000000000 * 2^14 / SEC_DIV): seconds estimate is angle * this >> 44
  localparam logic [31:0] SEC_EST_MUL   = 32'd3379442589;
  localparam int          SEC_EST_SHIFT = 44;
  localparam logic [20:0] RECIP_60   = 21'd1118481;
  localparam int          RECIP_SHIFT = 26;
  localparam logic [5:0]  SIXTY      = 6'd60;

  // atan(2^-i) in Q2.30
  function automatic logic [31:0] atan_q30(input int unsigned i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd843314857;
      1:  v = 32'd497837829;
      2:  v = 32'd263043837;
      3:  v = 32'd133525159;
      4:  v = 32'd67021687;
      5:  v = 32'd33543516;
      6:  v = 32'd16775851;
      7:  v = 32'd8388437;
      8:  v = 32'd4194283;
      9:  v = 32'd2097149;
      10: v = 32'd1048576;
      11: v = 32'd524288;
      12: v = 32'd262144;
      13: v = 32'd131072;
      14: v = 32'd65536;
      15: v = 32'd32768;
      16: v = 32'd16384;
      17: v = 32'd8192;
      18: v = 32'd4096;
      19: v = 32'd2048;
      20: v = 32'd1024;
      21: v = 32'd512;
      22: v = 32'd256;
      23: v = 32'd128;
      24: v = 32'd64;
      25: v = 32'd32;
      26: v = 32'd16;
      27: v = 32'd8;
      28: v = 32'd4;
      29: v = 32'd2;
      30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/tafs_front.sv =====
// Input stage: takes items, masks the sides and runs the triangle test.
`timescale 1ns / 1ps
module tafs_front #(
  parameter int SIDE_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tafs_pkg::in_item_t  in_item_i,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output tafs_pkg::job_t      job_o
);

  localparam int SW1 = SIDE_BITS + 1;

  logic [SIDE_BITS-1:0] a, b, c;
  logic                 fv_q;
  tafs_pkg::job_t       job_d, job_q;

  assign a = SIDE_BITS'(in_item_i.side_a);
  assign b = SIDE_BITS'(in_item_i.side_b);
  assign c = SIDE_BITS'(in_item_i.side_c);

  always_comb begin
    job_d.sides.side_a = 16'(a);
    job_d.sides.side_b = 16'(b);
    job_d.sides.side_c = 16'(c);
    job_d.is_tri = (SW1'(a) + SW1'(b) > SW1'(c)) &&
                   (SW1'(b) + SW1'(c) > SW1'(a)) &&
                   (SW1'(a) + SW1'(c) > SW1'(b));
  end

  assign in_ready_o  = !fv_q || job_ready_i;
  assign job_valid_o = fv_q;
  assign job_o       = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      fv_q <= 1'b1;
    end else if (job_ready_i) begin
      fv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      job_q <= job_d;
    end
  end

endmodule

// ===== rtl/tafs_queue.sv =====
// Short FIFO between the classifying front and the angle back end.
`timescale 1ns / 1ps
module tafs_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  tafs_pkg::job_t  push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output tafs_pkg::job_t  pop_data_o
);

  tafs_pkg::job_t                 mem_q [tafs_pkg::QUEUE_DEPTH];
  logic [tafs_pkg::QPTR_BITS-1:0] wr_q, rd_q;
  logic [tafs_pkg::QPTR_BITS:0]   cnt_q;
  logic                           push, pop;

  assign push_ready_o = cnt_q != (tafs_pkg::QPTR_BITS+1)'(tafs_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/tafs_angle_pipe.sv =====
// Arithmetic pipeline: cosine quotient, square root, CORDIC arccos, DMS conversion.
`timescale 1ns / 1ps
module tafs_angle_pipe #(
  parameter int SIDE_BITS    = 16,
  parameter int CORDIC_STEPS = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    in_valid_i,
  input  tafs_pkg::tag_t          in_tag_i,
  input  logic [SIDE_BITS-1:0]    x_i,
  input  logic [SIDE_BITS-1:0]    y_i,
  input  logic [SIDE_BITS-1:0]    z_i,
  output logic                    out_valid_o,
  output tafs_pkg::out_item_t     out_item_o
);

  localparam int SQ   = 2 * SIDE_BITS;
  localparam int RW   = 2 * SIDE_BITS + 2;
  localparam int QB   = tafs_pkg::QUO_BITS;
  localparam int NB   = 63;
  localparam int RT   = 32;
  localparam int CW   = 34;
  localparam int SB   = tafs_pkg::SEC_BITS;
  localparam int SCB  = tafs_pkg::SCALED_BITS;
  localparam int LAT  = 76 + CORDIC_STEPS;

  // valid and tag line, one entry per register stage
  logic [LAT-1:0]  vld_q;
  tafs_pkg::tag_t  tag_q [LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0] <= in_tag_i;
      for (int i = 1; i < LAT; i++) tag_q[i] <= tag_q[i-1];
    end
  end

  // squares and product
  logic [SQ-1:0] xx_q, yy_q, zz_q, xy_q;
  logic [SQ:0]   p_q, den1_q;
  logic [SQ-1:0] zz1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xx_q   <= SQ'(x_i) * SQ'(x_i);
      yy_q   <= SQ'(y_i) * SQ'(y_i);
      zz_q   <= SQ'(z_i) * SQ'(z_i);
      xy_q   <= SQ'(x_i) * SQ'(y_i);
      p_q    <= (SQ+1)'(xx_q) + (SQ+1)'(yy_q);
      zz1_q  <= zz_q;
      den1_q <= {xy_q, 1'b0};
    end
  end

  // restoring divider, one quotient bit per stage
  logic [RW-1:0] drem_q [QB+1];
  logic [RW-1:0] dden_q [QB+1];
  logic [QB-1:0] dquo_q [QB+1];
  logic          dneg_q [QB+1];
  logic [RW-1:0] dsh    [QB+1];
  logic [RW-1:0] drem_d [QB+1];
  logic [QB-1:0] dquo_d [QB+1];

  always_comb begin
    dsh[0]    = '0;
    drem_d[0] = '0;
    dquo_d[0] = '0;
    for (int j = 1; j <= QB; j++) begin
      dsh[j] = {drem_q[j-1][RW-2:0], 1'b0};
      if (dsh[j] >= dden_q[j-1]) begin
        drem_d[j] = dsh[j] - dden_q[j-1];
        dquo_d[j] = {dquo_q[j-1][QB-2:0], 1'b1};
      end else begin
        drem_d[j] = dsh[j];
        dquo_d[j] = {dquo_q[j-1][QB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dneg_q[0] <= p_q < (SQ+1)'(zz1_q);
      drem_q[0] <= (p_q < (SQ+1)'(zz1_q)) ? RW'((SQ+1)'(zz1_q) - p_q)
                                           : RW'(p_q - (SQ+1)'(zz1_q));
      dden_q[0] <= RW'(den1_q);
      dquo_q[0] <= '0;
      for (int j = 1; j <= QB; j++) begin
        drem_q[j] <= drem_d[j];
        dquo_q[j] <= dquo_d[j];
        dden_q[j] <= dden_q[j-1];
        dneg_q[j] <= dneg_q[j-1];
      end
    end
  end

  // sin term: floor(sqrt(2^60 - q^2)), one result bit per stage
  logic [QB-1:0]   aq_q;
  logic [2*QB-1:0] aqsq_q;
  logic            aneg_q;
  logic [NB-1:0]   sn_q   [RT+1];
  logic [NB-1:0]   sres_q [RT+1];
  logic [QB-1:0]   saq_q  [RT+1];
  logic            sneg_q [RT+1];
  logic [NB-1:0]   st     [RT+1];
  logic [NB-1:0]   sn_d   [RT+1];
  logic [NB-1:0]   sres_d [RT+1];

  always_comb begin
    st[0]     = '0;
    sn_d[0]   = '0;
    sres_d[0] = '0;
    for (int i = 1; i <= RT; i++) begin
      st[i] = sres_q[i-1] + (NB'(1) << (64 - 2 * i));
      if (sn_q[i-1] >= st[i]) begin
        sn_d[i]   = sn_q[i-1] - st[i];
        sres_d[i] = (sres_q[i-1] >> 1) + (NB'(1) << (64 - 2 * i));
      end else begin
        sn_d[i]   = sn_q[i-1];
        sres_d[i] = sres_q[i-1] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      aq_q      <= dquo_q[QB];
      // a negative numerator that truncates to a zero cosine counts as positive
      aneg_q    <= dneg_q[QB] && (dquo_q[QB] != '0);
      aqsq_q    <= (2*QB)'(dquo_q[QB]) * (2*QB)'(dquo_q[QB]);
      sn_q[0]   <= NB'((2*QB+1)'(1) << (2*QB)) - NB'(aqsq_q);
      sres_q[0] <= '0;
      saq_q[0]  <= aq_q;
      sneg_q[0] <= aneg_q;
      for (int i = 1; i <= RT; i++) begin
        sn_q[i]   <= sn_d[i];
        sres_q[i] <= sres_d[i];
        saq_q[i]  <= saq_q[i-1];
        sneg_q[i] <= sneg_q[i-1];
      end
    end
  end

  // vectoring CORDIC, one rotation per stage
  logic signed [CW-1:0] cx_q [CORDIC_STEPS];
  logic signed [CW-1:0] cy_q [CORDIC_STEPS];
  logic signed [CW-1:0] cz_q [CORDIC_STEPS];
  logic                 cneg_q [CORDIC_STEPS];
  logic signed [CW-1:0] cx_in [CORDIC_STEPS];
  logic signed [CW-1:0] cy_in [CORDIC_STEPS];
  logic signed [CW-1:0] cz_in [CORDIC_STEPS];
  logic                 cneg_in [CORDIC_STEPS];

  always_comb begin
    cx_in[0]   = $signed(CW'(saq_q[RT]));
    cy_in[0]   = $signed(CW'(sres_q[RT]));
    cz_in[0]   = '0;
    cneg_in[0] = sneg_q[RT];
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      cx_in[i]   = cx_q[i-1];
      cy_in[i]   = cy_q[i-1];
      cz_in[i]   = cz_q[i-1];
      cneg_in[i] = cneg_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        cneg_q[i] <= cneg_in[i];
        if (!cy_in[i][CW-1]) begin
          cx_q[i] <= cx_in[i] + (cy_in[i] >>> i);
          cy_q[i] <= cy_in[i] - (cx_in[i] >>> i);
          cz_q[i] <= cz_in[i] + $signed(CW'(tafs_pkg::atan_q30(i)));
        end else begin
          cx_q[i] <= cx_in[i] - (cy_in[i] >>> i);
          cy_q[i] <= cy_in[i] + (cx_in[i] >>> i);
          cz_q[i] <= cz_in[i] - $signed(CW'(tafs_pkg::atan_q30(i)));
        end
      end
    end
  end

  // fold into [0, pi] and scale to arc seconds
  logic signed [CW:0] ang_s;
  logic [31:0]        ang_q;
  logic [62:0]        pl_q;
  logic [40:0]        ph_q;
  logic [63:0]        ep_q;
  logic [72:0]        prod;

  always_comb begin
    ang_s = cneg_q[CORDIC_STEPS-1]
          ? $signed((CW+1)'(tafs_pkg::PI_Q30)) - (CW+1)'(cz_q[CORDIC_STEPS-1])
          : (CW+1)'(cz_q[CORDIC_STEPS-1]);
    prod  = 73'(pl_q) + {ph_q, 32'd0};
  end

  // scaled / SEC_DIV: reciprocal estimate from the angle, low by at most one,
  // then one compare against the exact scaled value
  logic [SCB-1:0] nq_q, nq2_q, sd_q;
  logic [SB-1:0]  se_q, se2_q, s_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (ang_s < 0)                                      ang_q <= '0;
      else if (ang_s > $signed((CW+1)'(tafs_pkg::PI_Q30))) ang_q <= tafs_pkg::PI_Q30;
      else                                                ang_q <= ang_s[31:0];
      pl_q  <= 63'(ang_q) * 63'(tafs_pkg::SEC_MUL_LO);
      ph_q  <= 41'(ang_q) * 41'(tafs_pkg::SEC_MUL_HI);
      ep_q  <= 64'(ang_q) * 64'(tafs_pkg::SEC_EST_MUL);
      nq_q  <= prod[72:30];
      se_q  <= ep_q[tafs_pkg::SEC_EST_SHIFT +: SB];
      nq2_q <= nq_q;
      se2_q <= se_q;
      sd_q  <= SCB'(se_q) * SCB'(tafs_pkg::SEC_DIV);
      if (nq2_q - sd_q >= SCB'(tafs_pkg::SEC_DIV)) s_q <= se2_q + 1'b1;
      else                                         s_q <= se2_q;
    end
  end

  // split seconds by 60 twice: reciprocal estimate, then one correction
  logic [SB-1:0] s1_q;
  logic [13:0]   e1_q, m2_q, m3_q;
  logic [SB-1:0] r1;
  logic [5:0]    sec2_q, sec3_q, sec4_q, min4_q;
  logic [7:0]    e3_q, deg4_q;
  logic [13:0]   r3;
  logic [40:0]   e1p;
  logic [34:0]   e3p;

  always_comb begin
    e1p = 41'(s_q) * 41'(tafs_pkg::RECIP_60);
    r1  = s1_q - SB'(e1_q) * SB'(tafs_pkg::SIXTY);
    e3p = 35'(m2_q) * 35'(tafs_pkg::RECIP_60);
    r3  = m3_q - 14'(e3_q) * 14'(tafs_pkg::SIXTY);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s_q;
      e1_q <= e1p[tafs_pkg::RECIP_SHIFT +: 14];
      if (r1 >= SB'(tafs_pkg::SIXTY)) begin
        m2_q   <= e1_q + 1'b1;
        sec2_q <= 6'(r1 - SB'(tafs_pkg::SIXTY));
      end else begin
        m2_q   <= e1_q;
        sec2_q <= 6'(r1);
      end
      m3_q   <= m2_q;
      e3_q   <= e3p[tafs_pkg::RECIP_SHIFT +: 8];
      sec3_q <= sec2_q;
      if (r3 >= 14'(tafs_pkg::SIXTY)) begin
        deg4_q <= e3_q + 1'b1;
        min4_q <= 6'(r3 - 14'(tafs_pkg::SIXTY));
      end else begin
        deg4_q <= e3_q;
        min4_q <= 6'(r3);
      end
      sec4_q <= sec3_q;
    end
  end

  assign out_valid_o = vld_q[LAT-1];

  always_comb begin
    out_item_o.angle_index = tag_q[LAT-1].idx;
    out_item_o.degrees     = tag_q[LAT-1].is_tri ? deg4_q : '0;
    out_item_o.minutes     = tag_q[LAT-1].is_tri ? min4_q : '0;
    out_item_o.seconds     = tag_q[LAT-1].is_tri ? sec4_q : '0;
    out_item_o.is_triangle = tag_q[LAT-1].is_tri;
    out_item_o.last        = tag_q[LAT-1].last;
  end

endmodule

// ===== rtl/tafs_back.sv =====
// Back end: one pipeline job per angle, one per non-triangle; holds output register.
`timescale 1ns / 1ps
module tafs_back #(
  parameter int SIDE_BITS    = 16,
  parameter int CORDIC_STEPS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  output logic                 q_pop_o,
  input  tafs_pkg::job_t       q_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tafs_pkg::out_item_t  out_item_o
);

  logic [1:0]           k_q, k_d;
  logic                 en, issue;
  logic [SIDE_BITS-1:0] a, b, c, x, y, z;
  tafs_pkg::tag_t       tag;
  logic                 pv;
  tafs_pkg::out_item_t  pitem;
  logic                 out_valid_q;
  tafs_pkg::out_item_t  out_item_q;

  // whole pipeline moves when the output register can take a result
  assign en    = !out_valid_q || out_ready_i;
  assign issue = en && q_valid_i;

  assign a = SIDE_BITS'(q_data_i.sides.side_a);
  assign b = SIDE_BITS'(q_data_i.sides.side_b);
  assign c = SIDE_BITS'(q_data_i.sides.side_c);

  always_comb begin
    case (k_q)
      tafs_pkg::IDX_OPP_A: begin x = b; y = c; z = a; end
      tafs_pkg::IDX_OPP_B: begin x = c; y = a; z = b; end
      default:             begin x = a; y = b; z = c; end
    endcase
    tag.is_tri = q_data_i.is_tri;
    tag.idx    = q_data_i.is_tri ? k_q : tafs_pkg::IDX_OPP_C;
    tag.last   = !q_data_i.is_tri || (k_q == tafs_pkg::IDX_OPP_B);
    q_pop_o    = issue && tag.last;
    if (q_pop_o)     k_d = tafs_pkg::IDX_OPP_C;
    else if (issue)  k_d = k_q + 1'b1;
    else             k_d = k_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= tafs_pkg::IDX_OPP_C;
      out_valid_q <= 1'b0;
    end else begin
      k_q <= k_d;
      if (en) out_valid_q <= pv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_item_q <= pitem;
  end

  tafs_angle_pipe #(
    .SIDE_BITS    (SIDE_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (issue),
    .in_tag_i    (tag),
    .x_i         (x),
    .y_i         (y),
    .z_i         (z),
    .out_valid_o (pv),
    .out_item_o  (pitem)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  a_no_tri_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_item_q.is_triangle |->
      out_item_q.last && out_item_q.degrees == '0 && out_item_q.angle_index == '0)
    else $error("non-triangle result malformed");
  a_last_on_b : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.is_triangle |->
      out_item_q.last == (out_item_q.angle_index == tafs_pkg::IDX_OPP_B))
    else $error("last flag out of step with angle index");
  a_dms_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_item_q.minutes < 6'd60 && out_item_q.seconds < 6'd60)
    else $error("minutes or seconds out of range");
  a_pop_point : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o && q_data_i.is_tri |-> k_q == tafs_pkg::IDX_OPP_B)
    else $error("triangle item popped before third angle");
`endif

endmodule

// ===== rtl/triangle_angles_from_sides_dms.sv =====
// Top level: triangle angles in degrees, minutes and seconds from three sides.
// Throughput: one result per cycle while the output is not stalled; a triangle item
// yields three results, a non-triangle one. The rate is set by the single angle pipeline,
// which takes one angle job per cycle while the output register can take a result.
// Reset: asynchronous, active low; clears handshake and pipeline valid state only.
`timescale 1ns / 1ps
module triangle_angles_from_sides_dms #(
  parameter int SIDE_BITS    = 16,
  parameter int CORDIC_STEPS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tafs_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tafs_pkg::out_item_t  out_item_o
);

  logic            fj_valid, fj_ready;
  tafs_pkg::job_t  fj;
  logic            qj_valid, qj_pop;
  tafs_pkg::job_t  qj;

  tafs_front #(
    .SIDE_BITS (SIDE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .job_valid_o (fj_valid),
    .job_ready_i (fj_ready),
    .job_o       (fj)
  );

  tafs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fj_valid),
    .push_ready_o (fj_ready),
    .push_data_i  (fj),
    .pop_valid_o  (qj_valid),
    .pop_ready_i  (qj_pop),
    .pop_data_o   (qj)
  );

  tafs_back #(
    .SIDE_BITS    (SIDE_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (qj_valid),
    .q_pop_o     (qj_pop),
    .q_data_i    (qj),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
